>>> rtl/timed_union_find_macros.svh
// Assertion macros used by the checker file.
`ifndef TIMED_UNION_FIND_MACROS_SVH
`define TIMED_UNION_FIND_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TUF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TUF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/tuf_pkg.sv
// ----------------------------------------------------------------------------
// tuf_pkg
// Types and constants of the timed union-find block.
// ----------------------------------------------------------------------------
package tuf_pkg;

  localparam int unsigned NodeW = 10;
  localparam int unsigned TimeW = 32;

  localparam logic KindUnite = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic [TimeW-1:0] at_time;
  } in_word_t;

  typedef struct packed {
    logic answer;
    logic time_error;
  } out_word_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    CmdNone,
    CmdClear,     // write the reset entry of the node at the clear address, advance
    CmdSetTime,   // last unite time := at_time
    CmdLoadA,     // cursor node := node_a, restart the step count
    CmdLoadB,     // cursor node := node_b, restart the step count
    CmdLoadRb,    // cursor node := rb
    CmdLoadLink,  // cursor node := node that gets the parent link
    CmdRdTop,     // read the top entry of the cursor node, open the search window
    CmdRdMid,     // read the entry in the middle of the search window
    CmdRdLo,      // read the entry at the low end of the search window
    CmdNarrow,    // halve the search window with the entry just read
    CmdStep,      // follow the parent just read unless the walk ends here
    CmdSaveRa,    // ra := cursor node, va := value just read
    CmdSaveRb,    // rb := cursor node, vb := value just read
    CmdWrRank,    // write the rank entry vb - 1 for the cursor node
    CmdWrLink     // write the parent link for the cursor node
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
    logic top_hit;      // top entry time <= t
    logic search_done;  // hi - lo <= 1
    logic walk_done;    // value is a root or the step limit is reached
    logic same_root;
    logic time_back;
    logic bad_node;
    logic va_eq_vb;
  } sts_t;

endpackage

>>> rtl/timed_union_find.sv
// ----------------------------------------------------------------------------
// timed_union_find
// Semi-persistent union-find with timestamped per-node histories.
// ----------------------------------------------------------------------------
// Channel | Direction | Word
// in      | input     | tuf_pkg::in_word_t (kind, node_a, node_b, at_time)
// out     | output    | tuf_pkg::out_word_t (answer, time_error)
// After reset a clearing pass writes the reset entry of every node with in_ready_o low.
// Each node on a root walk reads its newest entry and binary-searches its
// history when that entry does not apply. A query walks both nodes to their
// roots; a unite also records its time and, when the roots differ, writes the
// parent link, after a rank entry when the ranks are equal.
// A finished word waits in the output register while the next one is taken.
module timed_union_find #(
  parameter int unsigned NODES         = 1024,
  parameter int unsigned HISTORY_DEPTH = 12,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tuf_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tuf_pkg::out_word_t out_word_o
);

  tuf_pkg::in_word_t item;
  tuf_pkg::ctl_t     ctl;
  tuf_pkg::sts_t     sts;

  tuf_control u_ctl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o,
    .item_o(item), .ctl_o(ctl), .sts_i(sts)
  );

  tuf_datapath #(
    .NODES(NODES), .HISTORY_DEPTH(HISTORY_DEPTH), .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .item_i(item), .ctl_i(ctl), .sts_o(sts)
  );

endmodule

>>> rtl/tuf_datapath.sv
// ----------------------------------------------------------------------------
// tuf_datapath
// History memories, root walk registers and write logic.
// ----------------------------------------------------------------------------
module tuf_datapath #(
  parameter int unsigned NODES         = 1024,
  parameter int unsigned HISTORY_DEPTH = 12,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tuf_pkg::in_word_t  item_i,
  input  tuf_pkg::ctl_t      ctl_i,
  output tuf_pkg::sts_t      sts_o
);

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned HW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned DEPTH = NODES * HISTORY_DEPTH;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned VW = NW + 1;
  localparam int unsigned SW = $clog2(NODES + 1);

  logic [TIME_BITS-1:0] mem_time [DEPTH];
  logic [VW-1:0]        mem_val  [DEPTH];
  logic [HW-1:0]        mem_cnt  [NODES];

  logic [TIME_BITS-1:0] rd_time_q;
  logic [VW-1:0]        rd_val_q;
  logic [HW-1:0]        cnt_q;
  logic [NW-1:0]        clr_q;
  logic [NW-1:0]        cur_q, ra_q, rb_q;
  logic [VW-1:0]        va_q, vb_q;
  logic [HW-1:0]        lo_q, hi_q;
  logic [SW-1:0]        steps_q;
  logic [TIME_BITS-1:0] last_q;

  logic [TIME_BITS-1:0] t;
  logic [NW-1:0]        na, nb;
  logic [HW:0]          mid_sum;
  logic [HW-1:0]        mid;
  logic [AW-1:0]        base, rd_addr, wr_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [TIME_BITS-1:0] wr_time;
  logic [VW-1:0]        wr_val;
  logic                 wr_cnt;
  logic [HW-1:0]        wr_cnt_val;
  logic [NW-1:0]        wr_node;
  logic                 fresh;
  logic                 walk_done;
  logic                 swap;
  logic [NW-1:0]        link_src, link_dst;

  assign t       = TIME_BITS'(item_i.at_time);
  assign na      = NW'(item_i.node_a);
  assign nb      = NW'(item_i.node_b);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[HW:1];
  assign base    = AW'(cur_q) * AW'(HISTORY_DEPTH);

  // Values compare as signed numbers; swap when va < vb.
  assign swap = $signed(va_q) < $signed(vb_q);
  assign link_src = swap ? rb_q : ra_q;
  assign link_dst = swap ? ra_q : rb_q;

  // A write appends a new entry only for a later time and while there is room.
  assign fresh = (rd_time_q < t) && (cnt_q < HW'(HISTORY_DEPTH));

  assign walk_done = rd_val_q[VW-1] || (rd_val_q >= VW'(NODES)) ||
                     (steps_q == SW'(NODES));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base + AW'(cnt_q) - AW'(1);
    unique case (ctl_i.cmd)
      tuf_pkg::CmdRdTop: rd_en = 1'b1;
      tuf_pkg::CmdRdMid: begin
        rd_en   = 1'b1;
        rd_addr = base + AW'(mid);
      end
      tuf_pkg::CmdRdLo: begin
        rd_en   = 1'b1;
        rd_addr = base + AW'(lo_q);
      end
      default: ;
    endcase
  end

  // Write path: cnt_q and rd_time_q hold the count and the top entry time of
  // the cursor node, which the controller reads just before the write.
  always_comb begin
    wr_en      = 1'b0;
    wr_cnt     = 1'b0;
    wr_addr    = base + AW'(cnt_q) - AW'(1);
    wr_time    = rd_time_q;
    wr_val     = '1;
    wr_node    = cur_q;
    wr_cnt_val = cnt_q + HW'(1);
    unique case (ctl_i.cmd)
      tuf_pkg::CmdClear: begin
        wr_en      = 1'b1;
        wr_cnt     = 1'b1;
        wr_addr    = AW'(clr_q) * AW'(HISTORY_DEPTH);
        wr_time    = '0;
        wr_node    = clr_q;
        wr_cnt_val = HW'(1);
      end
      tuf_pkg::CmdWrRank: begin
        wr_en  = 1'b1;
        wr_val = vb_q - VW'(1);
      end
      tuf_pkg::CmdWrLink: begin
        wr_en  = 1'b1;
        wr_val = VW'(link_dst);
      end
      default: ;
    endcase
    if ((ctl_i.cmd == tuf_pkg::CmdWrRank || ctl_i.cmd == tuf_pkg::CmdWrLink) && fresh) begin
      wr_addr = base + AW'(cnt_q);
      wr_time = t;
      wr_cnt  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_time[wr_addr] <= wr_time;
      mem_val[wr_addr]  <= wr_val;
    end
    if (wr_cnt) mem_cnt[wr_node] <= wr_cnt_val;
    if (rd_en) begin
      rd_time_q <= mem_time[rd_addr];
      rd_val_q  <= mem_val[rd_addr];
    end
    cnt_q <= mem_cnt[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      last_q  <= '0;
      cur_q   <= '0;
      ra_q    <= '0;
      rb_q    <= '0;
      va_q    <= '0;
      vb_q    <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      steps_q <= '0;
    end else begin
      unique case (ctl_i.cmd)
        tuf_pkg::CmdClear: begin
          if (clr_q != NW'(NODES - 1)) clr_q <= clr_q + NW'(1);
        end
        tuf_pkg::CmdSetTime: last_q <= t;
        tuf_pkg::CmdLoadA: begin
          cur_q   <= na;
          steps_q <= '0;
        end
        tuf_pkg::CmdLoadB: begin
          cur_q   <= nb;
          steps_q <= '0;
        end
        tuf_pkg::CmdLoadRb: cur_q <= rb_q;
        tuf_pkg::CmdLoadLink: cur_q <= link_src;
        tuf_pkg::CmdRdTop: begin
          lo_q <= '0;
          hi_q <= cnt_q;
        end
        tuf_pkg::CmdNarrow: begin
          if (rd_time_q <= t) lo_q <= mid;
          else hi_q <= mid;
        end
        tuf_pkg::CmdStep: begin
          if (!walk_done) begin
            cur_q   <= rd_val_q[NW-1:0];
            steps_q <= steps_q + SW'(1);
          end
        end
        tuf_pkg::CmdSaveRa: begin
          ra_q <= cur_q;
          va_q <= rd_val_q;
        end
        tuf_pkg::CmdSaveRb: begin
          rb_q <= cur_q;
          vb_q <= rd_val_q;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.clear_done  = clr_q == NW'(NODES - 1);
  assign sts_o.top_hit     = rd_time_q <= t;
  assign sts_o.search_done = (hi_q - lo_q) <= HW'(1);
  assign sts_o.walk_done   = walk_done;
  assign sts_o.same_root   = ra_q == rb_q;
  assign sts_o.time_back   = t < last_q;
  assign sts_o.bad_node    = 32'(item_i.node_a) >= NODES || 32'(item_i.node_b) >= NODES;
  assign sts_o.va_eq_vb    = va_q == vb_q;

endmodule

>>> rtl/tuf_control.sv
// ----------------------------------------------------------------------------
// tuf_control
// Sequencer for the root walks, the history search and the writes.
// ----------------------------------------------------------------------------
module tuf_control (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tuf_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tuf_pkg::out_word_t  out_word_o,
  output tuf_pkg::in_word_t   item_o,
  output tuf_pkg::ctl_t       ctl_o,
  input  tuf_pkg::sts_t       sts_i
);

  typedef enum logic [4:0] {
    StClear, StIdle, StStart, StSetTime, StLoad, StCnt, StTop, StTopChk,
    StSearch, StMidChk, StStep, StRoot, StDecide, StRankLoad, StRankCnt,
    StRankTop, StRankWr, StLinkLoad, StLinkCnt, StLinkTop, StLinkWr, StDone
  } state_e;

  state_e state_q;
  tuf_pkg::in_word_t item_q;
  tuf_pkg::out_word_t res_q;
  tuf_pkg::out_word_t out_q;
  logic out_valid_q;
  logic second_q;   // walking node_b
  logic load_out;

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign item_o      = item_q;
  assign load_out    = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctl_o.cmd = tuf_pkg::CmdNone;
    unique case (state_q)
      StClear: ctl_o.cmd = tuf_pkg::CmdClear;
      StSetTime: ctl_o.cmd = tuf_pkg::CmdSetTime;
      StLoad: ctl_o.cmd = second_q ? tuf_pkg::CmdLoadB : tuf_pkg::CmdLoadA;
      StTop: ctl_o.cmd = tuf_pkg::CmdRdTop;
      StSearch: ctl_o.cmd = sts_i.search_done ? tuf_pkg::CmdRdLo : tuf_pkg::CmdRdMid;
      StMidChk: ctl_o.cmd = tuf_pkg::CmdNarrow;
      StStep: ctl_o.cmd = tuf_pkg::CmdStep;
      StRoot: ctl_o.cmd = second_q ? tuf_pkg::CmdSaveRb : tuf_pkg::CmdSaveRa;
      StRankLoad: ctl_o.cmd = tuf_pkg::CmdLoadRb;
      StRankTop: ctl_o.cmd = tuf_pkg::CmdRdTop;
      StRankWr: ctl_o.cmd = tuf_pkg::CmdWrRank;
      StLinkLoad: ctl_o.cmd = tuf_pkg::CmdLoadLink;
      StLinkTop: ctl_o.cmd = tuf_pkg::CmdRdTop;
      StLinkWr: ctl_o.cmd = tuf_pkg::CmdWrLink;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      item_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StClear: if (sts_i.clear_done) state_q <= StIdle;
        StIdle: if (in_valid_i) begin
          item_q   <= in_word_i;
          second_q <= 1'b0;
          res_q    <= '0;
          state_q  <= StStart;
        end
        StStart: begin
          if (sts_i.bad_node) state_q <= StDone;
          else if (item_q.kind == tuf_pkg::KindUnite) begin
            if (sts_i.time_back) begin
              res_q.time_error <= 1'b1;
              state_q <= StDone;
            end else state_q <= StSetTime;
          end else state_q <= StLoad;
        end
        StSetTime: state_q <= StLoad;
        StLoad: state_q <= StCnt;
        StCnt: state_q <= StTop;        // count settles in cnt_q
        StTop: state_q <= StTopChk;     // top entry read issued
        StTopChk: state_q <= sts_i.top_hit ? StStep : StSearch;
        StSearch: state_q <= sts_i.search_done ? StStep : StMidChk;
        StMidChk: state_q <= StSearch;
        StStep: state_q <= sts_i.walk_done ? StRoot : StCnt;
        StRoot: begin
          if (second_q) state_q <= StDecide;
          else begin
            second_q <= 1'b1;
            state_q  <= StLoad;
          end
        end
        StDecide: begin
          if (item_q.kind == tuf_pkg::KindQuery) begin
            res_q.answer <= sts_i.same_root;
            state_q <= StDone;
          end else if (sts_i.same_root) state_q <= StDone;
          else begin
            res_q.answer <= 1'b1;
            state_q <= sts_i.va_eq_vb ? StRankLoad : StLinkLoad;
          end
        end
        StRankLoad: state_q <= StRankCnt;
        StRankCnt: state_q <= StRankTop;
        StRankTop: state_q <= StRankWr;
        StRankWr: state_q <= StLinkLoad;
        StLinkLoad: state_q <= StLinkCnt;
        StLinkCnt: state_q <= StLinkTop;
        StLinkTop: state_q <= StLinkWr;
        StLinkWr: state_q <= StDone;
        StDone: if (load_out) begin
          out_q   <= res_q;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> rtl/tuf_checker.sv
// ----------------------------------------------------------------------------
// tuf_checker
// Port-level checks of the timed union-find block.
// ----------------------------------------------------------------------------
`include "timed_union_find_macros.svh"
module tuf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tuf_pkg::out_word_t out_word_o
);
  // A taken item is not followed by another acceptance in the next cycle.
  `TUF_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A flagged result never claims a merge.
  `TUF_ASSERT_IMP(a_err_no_merge, clk_i, rst_ni, out_valid_o && out_word_o.time_error,
                  !out_word_o.answer)
  // Results hold while stalled.
  `TUF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(out_word_o))
endmodule

bind timed_union_find tuf_checker u_tuf_checker (.*);

>>> test/tb_timed_union_find.sv
// ----------------------------------------------------------------------------
// tb_timed_union_find
// Self-checking testbench for the timed union-find block. Words are sent with
// random bursts and gaps, results are taken under a varying stall pattern, and
// each result is compared with a behavioral model of the timestamped
// union-by-rank histories kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_timed_union_find;

  localparam int Nodes      = 1024;
  localparam int Depth      = 12;
  localparam int StallLimit = 60000;
  localparam logic [31:0] Latest = 32'hFFFF_FFFF;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tuf_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_ready;
  tuf_pkg::out_word_t out_word;

  // Model state: per-node timestamped history of parent or negative rank.
  logic [31:0] hist_time [Nodes][Depth];
  int          hist_val  [Nodes][Depth];
  int          hist_cnt  [Nodes];
  logic [31:0] last_unite;

  tuf_pkg::out_word_t pending_answers[$];
  int          mismatches;
  int          burst_left;
  logic [31:0] unite_clock;
  int          node_pool;

  timed_union_find u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int entry_at(int node, logic [31:0] t);
    int lo, hi, mid, cnt;
    cnt = hist_cnt[node];
    lo  = 0;
    hi  = cnt;
    if (hist_time[node][cnt-1] <= t) return hist_val[node][cnt-1];
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (hist_time[node][mid] <= t) lo = mid;
      else hi = mid;
    end
    return hist_val[node][lo];
  endfunction

  function automatic void record_entry(int node, int val, logic [31:0] t);
    int cnt;
    cnt = hist_cnt[node];
    if (hist_time[node][cnt-1] < t && cnt < Depth) begin
      hist_time[node][cnt] = t;
      hist_val[node][cnt]  = val;
      hist_cnt[node]       = cnt + 1;
    end else begin
      // A full history or a repeated timestamp rewrites the newest entry.
      hist_val[node][cnt-1] = val;
    end
  endfunction

  function automatic int root_at(int node, logic [31:0] t);
    int p;
    for (int s = 0; s < Nodes; s++) begin
      p = entry_at(node, t);
      if (p < 0 || p >= Nodes) break;
      node = p;
    end
    return node;
  endfunction

  function automatic tuf_pkg::out_word_t apply_word(tuf_pkg::in_word_t w);
    tuf_pkg::out_word_t r;
    int ra, rb, va, vb, tmp;
    r = '0;
    if (int'(w.node_a) >= Nodes || int'(w.node_b) >= Nodes) return r;
    if (w.kind == tuf_pkg::KindQuery) begin
      r.answer = (root_at(w.node_a, w.at_time) == root_at(w.node_b, w.at_time));
      return r;
    end
    if (w.at_time < last_unite) begin
      r.time_error = 1'b1;
      return r;
    end
    last_unite = w.at_time;
    ra = root_at(w.node_a, w.at_time);
    rb = root_at(w.node_b, w.at_time);
    if (ra != rb) begin
      va = entry_at(ra, w.at_time);
      vb = entry_at(rb, w.at_time);
      if (va == vb) begin
        record_entry(rb, vb - 1, w.at_time);
      end else if (va < vb) begin
        tmp = ra;
        ra  = rb;
        rb  = tmp;
      end
      record_entry(ra, rb, w.at_time);
      r.answer = 1'b1;
    end
    return r;
  endfunction

  // Sends one word; when the current burst runs out, a random gap may come first.
  task automatic send_word(logic k, logic [9:0] a, logic [9:0] b, logic [31:0] t);
    tuf_pkg::in_word_t w;
    w = '{kind: k, node_a: a, node_b: b, at_time: t};
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers.push_back(apply_word(w));
  endtask

  function automatic logic [9:0] pick_node();
    if ($urandom_range(0, 9) == 0) return 10'($urandom);
    return 10'($urandom_range(0, node_pool - 1));
  endfunction

  function automatic logic [31:0] pick_query_time();
    case ($urandom_range(0, 3))
      0:       return Latest;
      1:       return $urandom;
      default: return unite_clock - 32'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic random_mix(int count);
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 19) == 0 && unite_clock != 0) begin
          t = unite_clock - 32'($urandom_range(1, 50));
        end else begin
          unite_clock = unite_clock + 32'($urandom_range(0, 3));
          t = unite_clock;
        end
        send_word(tuf_pkg::KindUnite, pick_node(), pick_node(), t);
      end else begin
        send_word(tuf_pkg::KindQuery, pick_node(), pick_node(), pick_query_time());
      end
    end
  endtask

  task automatic test_directed();
    send_word(tuf_pkg::KindQuery, 10'd0, 10'd1023, Latest);
    send_word(tuf_pkg::KindUnite, 10'd0, 10'd1, 32'd0);
    send_word(tuf_pkg::KindUnite, 10'd2, 10'd3, 32'd5);
    send_word(tuf_pkg::KindUnite, 10'd1, 10'd3, 32'd5);   // same timestamp, overwrite
    send_word(tuf_pkg::KindUnite, 10'd0, 10'd2, 32'd6);   // already connected
    send_word(tuf_pkg::KindUnite, 10'd4, 10'd5, 32'd4);   // goes back in time
    send_word(tuf_pkg::KindQuery, 10'd0, 10'd3, 32'd4);
    send_word(tuf_pkg::KindQuery, 10'd0, 10'd3, 32'd5);
    send_word(tuf_pkg::KindQuery, 10'd0, 10'd1, 32'd0);
    send_word(tuf_pkg::KindUnite, 10'd1023, 10'd0, 32'd9);
    send_word(tuf_pkg::KindUnite, 10'd1022, 10'd1021, 32'd9);
    send_word(tuf_pkg::KindUnite, 10'd1021, 10'd3, 32'd12);
    send_word(tuf_pkg::KindQuery, 10'd1022, 10'd1023, 32'd11);
    send_word(tuf_pkg::KindQuery, 10'd1022, 10'd1023, 32'd12);
    send_word(tuf_pkg::KindQuery, 10'd1022, 10'd1023, Latest);
    send_word(tuf_pkg::KindQuery, 10'd7, 10'd7, 32'd0);
    send_word(tuf_pkg::KindUnite, 10'd7, 10'd7, 32'd12);
    unite_clock = 32'd12;
  endtask

  task automatic test_low_times();
    node_pool = 24;
    random_mix(400);
    node_pool = 200;
    random_mix(300);
  endtask

  task automatic test_high_times();
    unite_clock = 32'hF000_0000 | 32'($urandom_range(0, 255));
    node_pool = 64;
    random_mix(500);
  endtask

  // After a unite at the latest time, only further latest unites are accepted.
  task automatic test_latest_time();
    node_pool = 64;
    for (int i = 0; i < 80; i++) begin
      case ($urandom_range(0, 2))
        0:       send_word(tuf_pkg::KindUnite, pick_node(), pick_node(), Latest);
        1:       send_word(tuf_pkg::KindUnite, pick_node(), pick_node(), $urandom);
        default: send_word(tuf_pkg::KindQuery, pick_node(), pick_node(), pick_query_time());
      endcase
    end
  endtask

  // Result checking and receiver stall pattern.
  always @(posedge clk or negedge rst_n) begin
    tuf_pkg::out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %b", out_word);
        end else begin
          want = pending_answers.pop_front();
          if (out_word.answer !== want.answer || out_word.time_error !== want.time_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: answer %b/%b time_error %b/%b (expected/actual)",
                       want.answer, out_word.answer, want.time_error, out_word.time_error);
          end
        end
      end
      case (($time / 3000) % 3)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    for (int n = 0; n < Nodes; n++) begin
      for (int j = 0; j < Depth; j++) begin
        hist_time[n][j] = '0;
        hist_val[n][j]  = -1;
      end
      hist_cnt[n] = 1;
    end
    last_unite  = '0;
    mismatches  = 0;
    burst_left  = 0;
    unite_clock = '0;
    node_pool   = 16;
    in_valid    = 1'b0;
    in_word     = '0;
    rst_n       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_low_times();
    test_high_times();
    test_latest_time();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
